// ===== rtl/core/hte_pkg.sv =====
// Shared types, constants and saturating helpers of the hover thrust estimator.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none
package hte_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegGain  = 2'd0;
  localparam logic [1:0] RegLower = 2'd1;
  localparam logic [1:0] RegUpper = 2'd2;

  // Action codes of an input item.
  localparam logic [2:0] ActPredict = 3'd0;
  localparam logic [2:0] ActKalman  = 3'd1;
  localparam logic [2:0] ActSimple  = 3'd2;
  localparam logic [2:0] ActSet     = 3'd3;
  localparam logic [2:0] ActReinit  = 3'd4;

  // Gravity in Q8.24 and the simple update step gain in Q0.32.
  localparam logic signed [63:0] Gravity  = 64'sd164416717;
  localparam logic signed [63:0] StepGain = 64'sd4294967;

  localparam logic signed [63:0] SMax   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SMax65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;

  // Configuration register contents.
  typedef struct packed {
    logic [23:0] gain;
    logic [16:0] lower;
    logic [16:0] upper;
  } hte_cfg_t;

  // One operation for the serial multiply and divide unit.
  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic        [63:0] divisor;
    logic        [5:0]  sh;
    logic               div_mode;
  } hte_op_t;

  // Add with symmetric saturation to +-(2^63-1).
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > SMax65) return SMax;
    if (s < -SMax65) return -SMax;
    return s[63:0];
  endfunction

  // Saturate to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Limit the throttle state; the lower limit wins when the limits cross.
  function automatic logic signed [31:0] clamp_hover(input logic signed [31:0] x,
                                                     input logic [16:0] lo,
                                                     input logic [16:0] hi);
    logic signed [31:0] lo_s;
    logic signed [31:0] hi_s;
    logic signed [31:0] r;
    lo_s = {7'b0, lo, 8'b0};
    hi_s = {7'b0, hi, 8'b0};
    r = x;
    if (r > hi_s) r = hi_s;
    if (r < lo_s) r = lo_s;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hte_regs.sv =====
// APB-style configuration registers of the hover thrust estimator.
// Depends on hte_pkg for the register indexes and the hte_cfg_t struct.
`default_nettype none
module hte_regs (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output hte_pkg::hte_cfg_t     cfg_o
);
  import hte_pkg::*;

  hte_cfg_t cfg_q;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  // Register writes on a completed transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain  <= 24'd1310720;
      cfg_q.lower <= 17'd19661;
      cfg_q.upper <= 17'd52429;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        RegGain:  cfg_q.gain  <= pwdata[23:0];
        RegLower: cfg_q.lower <= pwdata[16:0];
        RegUpper: cfg_q.upper <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Read-back decoder.
  always_comb begin
    unique case (paddr[3:2])
      RegGain:  prdata = {8'b0, cfg_q.gain};
      RegLower: prdata = {15'b0, cfg_q.lower};
      RegUpper: prdata = {15'b0, cfg_q.upper};
      default:  prdata = 32'b0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/hte_muldiv.sv =====
// Bit-serial multiply, shift and divide unit of the hover thrust estimator.
// Depends on hte_pkg for hte_op_t and the saturation constant.
`default_nettype none
module hte_muldiv (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire hte_pkg::hte_op_t   op_i,
  output logic                    done_o,
  output logic signed [63:0]      result_o
);
  import hte_pkg::*;

  typedef enum logic [4:0] {
    U_IDLE  = 5'b00001,
    U_MUL   = 5'b00010,
    U_SHIFT = 5'b00100,
    U_DIV   = 5'b01000,
    U_DONE  = 5'b10000
  } unit_state_e;

  unit_state_e state_q, state_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [127:0] acc_q, acc_d;
  logic [63:0]  amag_q, amag_d;
  logic [63:0]  div_q, div_d;
  logic [63:0]  rem_q, rem_d;
  logic [5:0]   sh_q, sh_d;
  logic         dmode_q, dmode_d;
  logic         neg_q, neg_d;

  logic [64:0]  psum;
  logic [64:0]  trial;
  logic         ge;
  logic [63:0]  amag_in;
  logic [63:0]  bmag_in;
  logic [63:0]  mag;

  assign amag_in = op_i.a[63] ? 64'(-op_i.a) : op_i.a;
  assign bmag_in = op_i.b[63] ? 64'(-op_i.b) : op_i.b;

  // One partial product and one quotient bit per cycle.
  assign psum  = {1'b0, acc_q[127:64]} + (acc_q[0] ? {1'b0, amag_q} : 65'd0);
  assign trial = {rem_q, acc_q[127]};
  assign ge    = trial >= {1'b0, div_q};

  // Saturate the magnitude and apply the sign.
  assign mag      = (acc_q[127:63] != 65'd0) ? SMax : acc_q[63:0];
  assign result_o = neg_q ? -$signed(mag) : $signed(mag);
  assign done_o   = state_q == U_DONE;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    amag_d  = amag_q;
    div_d   = div_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    dmode_d = dmode_q;
    neg_d   = neg_q;
    unique case (state_q)
      U_IDLE: begin
        if (start_i) begin
          acc_d   = {64'b0, bmag_in};
          amag_d  = amag_in;
          div_d   = op_i.divisor;
          sh_d    = op_i.sh;
          dmode_d = op_i.div_mode;
          neg_d   = op_i.a[63] ^ op_i.b[63];
          rem_d   = 64'b0;
          cnt_d   = 7'd63;
          state_d = U_MUL;
        end
      end
      U_MUL: begin
        acc_d = {psum, acc_q[63:1]};
        if (cnt_q == 7'd0) begin
          if (dmode_q) begin
            cnt_d   = 7'd127;
            state_d = U_DIV;
          end else begin
            cnt_d   = {1'b0, sh_q};
            state_d = U_SHIFT;
          end
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
      U_SHIFT: begin
        if (cnt_q == 7'd0) begin
          state_d = U_DONE;
        end else begin
          acc_d = {1'b0, acc_q[127:1]};
          cnt_d = cnt_q - 7'd1;
        end
      end
      U_DIV: begin
        rem_d = ge ? 64'(trial - {1'b0, div_q}) : trial[63:0];
        acc_d = {acc_q[126:0], ge};
        if (cnt_q == 7'd0) state_d = U_DONE;
        else cnt_d = cnt_q - 7'd1;
      end
      U_DONE: state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= 7'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    amag_q  <= amag_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    sh_q    <= sh_d;
    dmode_q <= dmode_d;
    neg_q   <= neg_d;
  end

endmodule
`default_nettype wire

// ===== rtl/core/hover_thrust_kalman_estimator.sv =====
// Top level of the hover thrust estimator: sequencer, state and result register.
// Depends on hte_pkg, hte_regs and hte_muldiv.
//
// Usage: one input item per transfer on the in_* channel carries an action and
// its operands; each item yields exactly one result on the out_* channel with
// the hover estimate, the acceleration estimate and the limit flags.
// Set, reinitialize and unknown actions do not use the arithmetic unit. Every
// product and quotient goes through one bit-serial unit. Predict runs four
// multiplies, simple update two and the Kalman update six multiply-divides
// (none when p_q[3] plus the measurement noise is not positive). One item is
// in work at a time; the next is taken once the result has moved into the
// output register. The output register holds its result while the receiver
// stalls; the block finishes the next item and then waits until that register
// is free. Reset clears the estimates to zero, sets the covariance to its
// initial diagonal and restores the configuration registers.
`default_nettype none
module hover_thrust_kalman_estimator #(
  parameter int COV_FRAC_BITS = 55
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         action_i,
  input  wire logic [16:0]        throttle_cmd_i,
  input  wire logic signed [23:0] accel_z_i,
  input  wire logic [16:0]        hover_set_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [16:0]        hover_estimate_o,
  output logic signed [23:0]      accel_estimate_o,
  output logic                    at_lower_o,
  output logic                    at_upper_o
);
  import hte_pkg::*;

  localparam logic signed [63:0] MeasNoise =
      64'(((64'd1 << COV_FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic signed [63:0] P00Init = 64'(64'd1 << (COV_FRAC_BITS - 2));
  localparam logic signed [63:0] P11Init = 64'(64'd1 << COV_FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_OUT   = 4'b1000
  } seq_state_e;

  hte_cfg_t   cfg;
  hte_op_t    op;
  logic       unit_start;
  logic       unit_done;
  logic signed [63:0] unit_res;

  seq_state_e state_q;
  logic [2:0] step_q;
  logic [2:0] act_q;
  logic [16:0] u_q;
  logic signed [23:0] acc_q;
  logic [16:0] hs_q;
  logic signed [31:0] x0_q;
  logic signed [31:0] x1_q;
  logic signed [63:0] p_q [4];
  logic signed [63:0] tmp_q;
  logic signed [63:0] y_q;
  logic signed [63:0] s_q;

  logic signed [63:0] x0_ext;
  logic signed [63:0] x1_ext;
  logic signed [63:0] acc256;
  logic signed [63:0] u256;
  logic signed [63:0] u64;
  logic signed [63:0] g64;
  logic               last_step;
  logic               uses_unit;

  hte_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hte_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (unit_start),
    .op_i     (op),
    .done_o   (unit_done),
    .result_o (unit_res)
  );

  assign x0_ext = {{32{x0_q[31]}}, x0_q};
  assign x1_ext = {{32{x1_q[31]}}, x1_q};
  assign acc256 = {{32{acc_q[23]}}, acc_q, 8'b0};
  assign u256   = {39'b0, u_q, 8'b0};
  assign u64    = {47'b0, u_q};
  assign g64    = {40'b0, cfg.gain};

  assign in_ready_o = state_q == S_IDLE;
  assign uses_unit  = act_q == ActPredict || act_q == ActSimple ||
                      (act_q == ActKalman && s_q > 64'sd0);
  assign unit_start = state_q == S_ISSUE && uses_unit;

  // Operand selection for the current step.
  always_comb begin
    op = '{a: 64'sd0, b: 64'sd0, divisor: 64'd1, sh: 6'd0, div_mode: 1'b0};
    last_step = 1'b1;
    case (act_q)
      ActPredict: begin
        last_step = step_q == 3'd3;
        case (step_q)
          3'd0: begin op.a = g64; op.b = u256 - x0_ext; op.sh = 6'd16; end
          3'd1: begin op.a = p_q[0]; op.b = g64; op.sh = 6'd16; end
          3'd2: begin op.a = g64; op.b = g64; op.sh = 6'd0; end
          default: begin op.a = p_q[0]; op.b = tmp_q; op.sh = 6'd32; end
        endcase
      end
      ActKalman: begin
        last_step = step_q == 3'd5;
        op.div_mode = 1'b1;
        op.divisor  = s_q;
        case (step_q)
          3'd0: begin op.a = p_q[1]; op.b = y_q; end
          3'd1: begin op.a = p_q[3]; op.b = y_q; end
          3'd2: begin op.a = p_q[1]; op.b = p_q[2]; end
          3'd3: begin op.a = p_q[1]; op.b = p_q[3]; end
          3'd4: begin op.a = p_q[3]; op.b = p_q[2]; end
          default: begin op.a = p_q[3]; op.b = p_q[3]; end
        endcase
      end
      ActSimple: begin
        last_step = step_q == 3'd1;
        if (step_q == 3'd0) begin
          op.a = u64; op.b = g64; op.sh = 6'd8;
        end else begin
          op.a = tmp_q; op.b = StepGain; op.sh = 6'd32;
        end
      end
      default: ;
    endcase
  end

  // Sequencer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 3'd0;
      out_valid_o <= 1'b0;
    end else begin
      if (state_q == S_OUT && (!out_valid_o || out_ready_i)) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            step_q  <= 3'd0;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: state_q <= uses_unit ? S_WAIT : S_OUT;
        S_WAIT: begin
          if (unit_done) begin
            if (last_step) begin
              state_q <= S_OUT;
            end else begin
              step_q  <= step_q + 3'd1;
              state_q <= S_ISSUE;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_o || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Input capture and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x0_q   <= 32'sd0;
      x1_q   <= 32'sd0;
      p_q[0] <= P00Init;
      p_q[1] <= 64'sd0;
      p_q[2] <= 64'sd0;
      p_q[3] <= P11Init;
    end else begin
      if (state_q == S_ISSUE && !uses_unit) begin
        case (act_q)
          ActKalman: x0_q <= clamp_hover(x0_q, cfg.lower, cfg.upper);
          ActSet:    x0_q <= {7'b0, hs_q, 8'b0};
          ActReinit: begin
            x0_q   <= 32'sd0;
            x1_q   <= 32'sd0;
            p_q[0] <= P00Init;
            p_q[1] <= 64'sd0;
            p_q[2] <= 64'sd0;
            p_q[3] <= P11Init;
          end
          default: ;
        endcase
      end else if (state_q == S_WAIT && unit_done) begin
        case (act_q)
          ActPredict: begin
            case (step_q)
              3'd0: x1_q <= sat32(unit_res);
              3'd1: begin
                p_q[1] <= -unit_res;
                p_q[2] <= -unit_res;
              end
              3'd2: ;
              default: p_q[3] <= unit_res;
            endcase
          end
          ActKalman: begin
            case (step_q)
              3'd0: x0_q <= sat32(sat_add(x0_ext, unit_res));
              3'd1: x1_q <= sat32(sat_add(x1_ext, unit_res));
              3'd2: p_q[0] <= sat_add(p_q[0], -unit_res);
              3'd3: p_q[1] <= sat_add(p_q[1], -unit_res);
              3'd4: p_q[2] <= sat_add(p_q[2], -unit_res);
              default: begin
                p_q[3] <= sat_add(p_q[3], -unit_res);
                x0_q   <= clamp_hover(x0_q, cfg.lower, cfg.upper);
              end
            endcase
          end
          ActSimple: begin
            if (step_q != 3'd0) begin
              x0_q <= clamp_hover(sat32(x0_ext + unit_res), cfg.lower, cfg.upper);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Item registers and intermediate values; no reset needed.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      act_q <= action_i;
      u_q   <= throttle_cmd_i;
      acc_q <= accel_z_i;
      hs_q  <= hover_set_i;
      y_q   <= {{32{accel_z_i[23]}}, accel_z_i, 8'b0} - Gravity - x1_ext;
      s_q   <= sat_add(p_q[3], MeasNoise);
    end
    if (state_q == S_WAIT && unit_done) begin
      if (act_q == ActPredict && step_q == 3'd2) tmp_q <= unit_res;
      if (act_q == ActSimple && step_q == 3'd0) tmp_q <= unit_res - acc256;
    end
  end

  // Result register, loaded when the previous result has been taken.
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!out_valid_o || out_ready_i)) begin
      if (x0_q <= 32'sd0) hover_estimate_o <= 17'd0;
      else if (x0_q[31:8] > 24'd65536) hover_estimate_o <= 17'd65536;
      else hover_estimate_o <= x0_q[24:8];
      accel_estimate_o <= x1_q[31:8];
      at_lower_o <= x0_q == {7'b0, cfg.lower, 8'b0};
      at_upper_o <= x0_q == {7'b0, cfg.upper, 8'b0};
    end
  end

endmodule
`default_nettype wire
